>>> hdl/qpht_pkg.sv
`timescale 1ns / 1ps

package qpht_pkg;

  localparam int CNT_W     = 11;
  localparam int RC_W      = 11;
  localparam int MAXA_W    = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 11;

  localparam logic [RC_W-1:0]   ROW_COUNT_RST  = 11'd1021;
  localparam logic [MAXA_W-1:0] MAX_ACTIVE_RST = 10'd510;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT  = 2'd0,
    REG_MAX_ACTIVE = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_FIND   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    POL_ALWAYS  = 2'd0,
    POL_ABSENT  = 2'd1,
    POL_PRESENT = 2'd2,
    POL_OTHER   = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_REFUSED  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_ACTIVE  = 2'd1,
    MARK_DELETED = 2'd2,
    MARK_UNUSED  = 2'd3
  } mark_t;

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_DIV  = 6'b000100,
    S_RD   = 6'b001000,
    S_CHK  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  typedef struct packed {
    logic accept;
    logic clr_start;
    logic clr_step;
    logic div_step;
    logic rd;
    logic chk;
    logic fin;
  } ctl_t;

  typedef struct packed {
    logic is_clear;
    logic skip_probe;
    logic clr_last;
    logic div_last;
    logic bound_hit;
    logic chk_stop;
    logic out_busy;
  } sts_t;

endpackage

>>> hdl/qpht_if.sv
`timescale 1ns / 1ps

interface qpht_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] key;
  logic [31:0] hash;
  logic [31:0] value;
  logic [1:0]  policy;
  modport source (output valid, cmd, key, hash, value, policy, input ready);
  modport sink (input valid, cmd, key, hash, value, policy, output ready);
endinterface

interface qpht_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        found;
  logic [31:0] value_out;
  logic [9:0]  row_index;
  modport source (output valid, status, found, value_out, row_index, input ready);
  modport sink (input valid, status, found, value_out, row_index, output ready);
endinterface

>>> hdl/qpht_ctrl.sv
`timescale 1ns / 1ps

module qpht_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  qpht_pkg::sts_t sts,
  output qpht_pkg::ctl_t ctl
);

  qpht_pkg::state_t state_r, state_nxt;
  logic resp_r, resp_nxt;

  assign in_ready = (state_r == qpht_pkg::S_IDLE);

  always_comb begin
    ctl           = '0;
    ctl.accept    = in_ready && in_valid;
    ctl.clr_start = ctl.accept && sts.is_clear;
    ctl.clr_step  = (state_r == qpht_pkg::S_CLR);
    ctl.div_step  = (state_r == qpht_pkg::S_DIV);
    ctl.rd        = (state_r == qpht_pkg::S_RD) && !sts.bound_hit;
    ctl.chk       = (state_r == qpht_pkg::S_CHK);
    ctl.fin       = (state_r == qpht_pkg::S_FIN) && !sts.out_busy;
  end

  always_comb begin
    state_nxt = state_r;
    resp_nxt  = resp_r;
    unique case (state_r)
      qpht_pkg::S_CLR: begin
        if (sts.clr_last) begin
          state_nxt = resp_r ? qpht_pkg::S_FIN : qpht_pkg::S_IDLE;
          resp_nxt  = 1'b0;
        end
      end
      qpht_pkg::S_IDLE: begin
        if (ctl.accept) begin
          priority if (sts.is_clear) begin
            state_nxt = qpht_pkg::S_CLR;
            resp_nxt  = 1'b1;
          end else if (sts.skip_probe) begin
            state_nxt = qpht_pkg::S_FIN;
          end else begin
            state_nxt = qpht_pkg::S_DIV;
          end
        end
      end
      qpht_pkg::S_DIV: if (sts.div_last) state_nxt = qpht_pkg::S_RD;
      qpht_pkg::S_RD:  state_nxt = sts.bound_hit ? qpht_pkg::S_FIN : qpht_pkg::S_CHK;
      qpht_pkg::S_CHK: state_nxt = sts.chk_stop ? qpht_pkg::S_FIN : qpht_pkg::S_RD;
      qpht_pkg::S_FIN: if (!sts.out_busy) state_nxt = qpht_pkg::S_IDLE;
      default:         state_nxt = qpht_pkg::S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qpht_pkg::S_CLR;
      resp_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      resp_r  <= resp_nxt;
    end
  end

endmodule

>>> hdl/qpht_datapath.sv
`timescale 1ns / 1ps

module qpht_datapath #(
  parameter int ROWS        = 1024,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32,
  parameter int HASH_WIDTH  = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [1:0]                       in_cmd,
  input  logic [31:0]                      in_key,
  input  logic [31:0]                      in_hash,
  input  logic [31:0]                      in_value,
  input  logic [1:0]                       in_policy,
  input  logic                             cfg_we,
  input  logic [qpht_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [qpht_pkg::CFG_W-1:0]       cfg_data,
  input  qpht_pkg::ctl_t                   ctl,
  output qpht_pkg::sts_t                   sts,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [1:0]                       out_status,
  output logic                             out_found,
  output logic [31:0]                      out_value,
  output logic [9:0]                       out_row
);

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(ROWS + 1);
  localparam int SW = CW + 1;
  localparam int DW = $clog2(HASH_WIDTH);

  // table storage
  logic [1:0]             mark_mem [ROWS];
  logic [KEY_WIDTH-1:0]   key_mem  [ROWS];
  logic [VALUE_WIDTH-1:0] val_mem  [ROWS];
  logic [1:0]             mark_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] val_q;

  logic [qpht_pkg::RC_W-1:0]   row_count_r;
  logic [qpht_pkg::MAXA_W-1:0] max_active_r;
  logic [qpht_pkg::CNT_W-1:0]  active_r, deleted_r;

  qpht_pkg::cmd_t         cmd_r;
  logic [1:0]             policy_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic [HASH_WIDTH-1:0]  hash_r;

  logic [CW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dcnt_r;
  logic [RW-1:0] x_r, inc_r, tomb_r, clr_cnt_r;
  logic [CW-1:0] i_r;
  logic          have_tomb_r, empty_seen_r, found_r;

  logic [CW-1:0] rc;
  logic [SW-1:0] rc_x;
  logic [16:0]   rc_w;

  always_comb begin
    rc_w = 17'(row_count_r);
    if (rc_w == 17'd0)          rc = CW'(1);
    else if (rc_w > 17'(ROWS))  rc = CW'(ROWS);
    else                        rc = CW'(row_count_r);
    rc_x = SW'(rc);
  end

  // one quotient bit per cycle
  logic [SW-1:0] dtrial;
  always_comb begin
    dtrial  = {rem_r, hash_r[HASH_WIDTH-1]};
    rem_nxt = (dtrial >= rc_x) ? CW'(dtrial - rc_x) : CW'(dtrial);
  end

  // next probe row and next odd step, both reduced by one subtract
  logic [SW-1:0] xs, is;
  logic [RW-1:0] x_nxt, inc_nxt;
  always_comb begin
    xs    = SW'(x_r) + SW'(inc_r);
    x_nxt = (xs >= rc_x) ? RW'(xs - rc_x) : RW'(xs);
    is    = SW'(inc_r) + SW'(2);
    if (rc == CW'(1))    inc_nxt = '0;
    else if (is >= rc_x) inc_nxt = RW'(is - rc_x);
    else                 inc_nxt = RW'(is);
  end

  logic key_hit;
  assign key_hit = (mark_q == qpht_pkg::MARK_ACTIVE) && (key_q == key_r);

  always_comb begin
    sts            = '0;
    sts.is_clear   = (in_cmd == qpht_pkg::CMD_CLEAR);
    sts.skip_probe = (in_cmd == qpht_pkg::CMD_FIND || in_cmd == qpht_pkg::CMD_REMOVE)
                     && (active_r == '0);
    sts.clr_last   = (clr_cnt_r == RW'(ROWS - 1));
    sts.div_last   = (dcnt_r == DW'(HASH_WIDTH - 1));
    sts.bound_hit  = (i_r == rc);
    sts.chk_stop   = (mark_q == qpht_pkg::MARK_EMPTY) || key_hit;
    sts.out_busy   = out_valid && !out_ready;
  end

  // finishing decision
  logic [RW-1:0]              free_row, row_sel;
  logic                       has_free;
  logic [qpht_pkg::CNT_W-1:0] sum_rows, next_rows;
  logic [1:0]                 st_sel;
  logic                       fnd_sel;
  logic [VALUE_WIDTH-1:0]     v_sel;
  logic                       mw_en, kw_en, vw_en;
  logic [RW-1:0]              mw_addr;
  logic [1:0]                 mw_data;
  logic                       inc_act, dec_act, inc_del, dec_del;

  always_comb begin
    free_row  = have_tomb_r ? tomb_r : x_r;
    has_free  = empty_seen_r || have_tomb_r;
    sum_rows  = active_r + deleted_r;
    next_rows = have_tomb_r ? sum_rows : sum_rows + qpht_pkg::CNT_W'(1);
    st_sel    = qpht_pkg::ST_DONE;
    fnd_sel   = 1'b0;
    v_sel     = '0;
    row_sel   = '0;
    mw_en     = 1'b0;
    kw_en     = 1'b0;
    vw_en     = 1'b0;
    mw_addr   = x_r;
    mw_data   = qpht_pkg::MARK_EMPTY;
    inc_act   = 1'b0;
    dec_act   = 1'b0;
    inc_del   = 1'b0;
    dec_del   = 1'b0;
    unique case (cmd_r)
      qpht_pkg::CMD_CLEAR: ;
      qpht_pkg::CMD_FIND, qpht_pkg::CMD_REMOVE: begin
        if (found_r) begin
          fnd_sel = 1'b1;
          v_sel   = val_q;
          row_sel = x_r;
          if (cmd_r == qpht_pkg::CMD_REMOVE) begin
            mw_en   = 1'b1;
            mw_data = qpht_pkg::MARK_DELETED;
            dec_act = 1'b1;
            inc_del = 1'b1;
          end
        end else begin
          st_sel = qpht_pkg::ST_NOTFOUND;
        end
      end
      qpht_pkg::CMD_INSERT: begin
        if (found_r) begin
          fnd_sel = 1'b1;
          row_sel = x_r;
          if (policy_r == qpht_pkg::POL_ABSENT) begin
            st_sel = qpht_pkg::ST_REFUSED;
            v_sel  = val_q;
          end else begin
            vw_en = 1'b1;
            v_sel = value_r;
          end
        end else if (policy_r == qpht_pkg::POL_PRESENT) begin
          st_sel = qpht_pkg::ST_REFUSED;
        end else if (!has_free || next_rows >= qpht_pkg::CNT_W'(max_active_r)) begin
          st_sel = qpht_pkg::ST_FULL;
        end else begin
          row_sel = free_row;
          mw_en   = 1'b1;
          mw_addr = free_row;
          mw_data = qpht_pkg::MARK_ACTIVE;
          kw_en   = 1'b1;
          vw_en   = 1'b1;
          inc_act = 1'b1;
          dec_del = have_tomb_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.clr_step) begin
      mark_mem[clr_cnt_r] <= qpht_pkg::MARK_EMPTY;
    end else if (ctl.fin && mw_en) begin
      mark_mem[mw_addr] <= mw_data;
    end
    if (ctl.fin && kw_en) key_mem[mw_addr] <= key_r;
    if (ctl.fin && vw_en) val_mem[mw_addr] <= value_r;
    if (ctl.rd) begin
      mark_q <= mark_mem[x_r];
      key_q  <= key_mem[x_r];
      val_q  <= val_mem[x_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r  <= qpht_pkg::ROW_COUNT_RST;
      max_active_r <= qpht_pkg::MAX_ACTIVE_RST;
      active_r     <= '0;
      deleted_r    <= '0;
      clr_cnt_r    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == qpht_pkg::REG_ROW_COUNT) row_count_r <= cfg_data;
        if (cfg_index == qpht_pkg::REG_MAX_ACTIVE) max_active_r <= cfg_data[qpht_pkg::MAXA_W-1:0];
      end
      if (ctl.clr_start) begin
        active_r  <= '0;
        deleted_r <= '0;
        clr_cnt_r <= '0;
      end else if (ctl.clr_step) begin
        clr_cnt_r <= sts.clr_last ? '0 : clr_cnt_r + RW'(1);
      end else if (ctl.fin) begin
        if (inc_act) active_r <= active_r + qpht_pkg::CNT_W'(1);
        if (dec_act) active_r <= active_r - qpht_pkg::CNT_W'(1);
        if (inc_del) deleted_r <= deleted_r + qpht_pkg::CNT_W'(1);
        if (dec_del) deleted_r <= deleted_r - qpht_pkg::CNT_W'(1);
      end
      if (ctl.fin)        out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  logic [16:0] row_w;
  assign row_w = 17'(row_sel);

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r        <= qpht_pkg::cmd_t'(in_cmd);
      policy_r     <= in_policy;
      key_r        <= KEY_WIDTH'(in_key);
      value_r      <= VALUE_WIDTH'(in_value);
      hash_r       <= HASH_WIDTH'(in_hash);
      rem_r        <= '0;
      dcnt_r       <= '0;
      found_r      <= 1'b0;
      empty_seen_r <= 1'b0;
      have_tomb_r  <= 1'b0;
    end
    if (ctl.div_step) begin
      rem_r  <= rem_nxt;
      hash_r <= hash_r << 1;
      dcnt_r <= dcnt_r + DW'(1);
      if (sts.div_last) begin
        x_r   <= RW'(rem_nxt);
        inc_r <= RW'(rc != CW'(1));
        i_r   <= '0;
      end
    end
    if (ctl.chk) begin
      priority if (mark_q == qpht_pkg::MARK_EMPTY) begin
        empty_seen_r <= 1'b1;
      end else if (key_hit) begin
        found_r <= 1'b1;
      end else begin
        if (mark_q == qpht_pkg::MARK_DELETED && !have_tomb_r) begin
          have_tomb_r <= 1'b1;
          tomb_r      <= x_r;
        end
        x_r   <= x_nxt;
        inc_r <= inc_nxt;
        i_r   <= i_r + CW'(1);
      end
    end
    if (ctl.fin) begin
      out_status <= st_sel;
      out_found  <= fnd_sel;
      out_value  <= 32'(v_sel);
      out_row    <= row_w[9:0];
    end
  end

endmodule

>>> hdl/quadratic_probe_hash_table_top.sv
`timescale 1ns / 1ps
// Flow: the hash is first reduced by the row count (one remainder bit per cycle),
// then each probed row takes a memory read (S_RD) and a compare (S_CHK), and the
// result is registered from S_FIN; a probe that runs out of rows ends with one more
// S_RD. Find/remove on an empty table skip straight to S_FIN. One item at a time:
// no beat is taken until the last one has left S_FIN; the next beat is taken while
// a result waits. Clear all: mark sweep of all ROWS rows, then a result.
// Reset (rst_n low, synchronous): the same sweep, no beats taken meanwhile.

module quadratic_probe_hash_table_top #(
  parameter int ROWS        = 1024,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32,
  parameter int HASH_WIDTH  = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  qpht_in_if.sink                        in_ch,
  qpht_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [qpht_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qpht_pkg::CFG_W-1:0]     cfg_data
);

  qpht_pkg::ctl_t ctl;
  qpht_pkg::sts_t sts;
  logic           in_ready;

  assign in_ch.ready = in_ready;

  qpht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  qpht_datapath #(
    .ROWS        (ROWS),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .HASH_WIDTH  (HASH_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_cmd     (in_ch.cmd),
    .in_key     (in_ch.key),
    .in_hash    (in_ch.hash),
    .in_value   (in_ch.value),
    .in_policy  (in_ch.policy),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ctl        (ctl),
    .sts        (sts),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_status (out_ch.status),
    .out_found  (out_ch.found),
    .out_value  (out_ch.value_out),
    .out_row    (out_ch.row_index)
  );

endmodule

>>> hdl/qpht_checker.sv
`timescale 1ns / 1ps

module qpht_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic        out_found,
  input logic [31:0] out_value,
  input logic [9:0]  out_row
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_found)
      && $stable(out_value) && $stable(out_row))
    else $error("result changed while stalled");

  // one item in flight: ready drops after a beat is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while busy");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == qpht_pkg::ST_NOTFOUND |->
      !out_found && out_value == 32'd0 && out_row == 10'd0)
    else $error("not-found result carries data");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == qpht_pkg::ST_FULL |->
      !out_found && out_value == 32'd0 && out_row == 10'd0)
    else $error("table-full result carries data");

  a_value_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_value == 32'd0)
    else $error("value returned without a hit");

endmodule

bind quadratic_probe_hash_table_top qpht_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_found  (out_ch.found),
  .out_value  (out_ch.value_out),
  .out_row    (out_ch.row_index)
);
